// ===== rtl/c1d_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the 1-d convolution layer
// no dependencies; imported by c1d_mac, the top level, the test checker and the testbench
package c1d_pkg;

  // field widths
  localparam int unsigned ValW  = 16;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned PosW  = 16;
  localparam int unsigned FilW  = 3;
  localparam int unsigned ResW  = 32;
  localparam int unsigned AccW  = 40;
  localparam int unsigned CfgW  = 4;
  localparam int unsigned CfgAW = 2;

  // input beat kinds carried in tuser
  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_BIAS   = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // configuration register indexes
  localparam logic [CfgAW-1:0] CFG_FILTERS  = 2'd0;
  localparam logic [CfgAW-1:0] CFG_TAPS     = 2'd1;
  localparam logic [CfgAW-1:0] CFG_CHANNELS = 2'd2;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic            load;      // start a new sum with the bias
    logic [ValW-1:0] bias;
    logic            rd_valid;  // memory read data valid this cycle
  } mac_ctrl_t;

  // register value forced into 1..hi
  function automatic logic [CfgW-1:0] clamp_cfg(input logic [CfgW-1:0] v, input int hi);
    logic [CfgW-1:0] r;
    r = v;
    if (v == '0) r = CfgW'(1);
    else if (int'(v) > hi) r = CfgW'(hi);
    return r;
  endfunction

endpackage

// ===== rtl/c1d_mac.sv =====
`timescale 1ns / 1ps
// multiply-accumulate unit: registered 16x16 product, 40-bit sum, 32-bit saturation
// depends on c1d_pkg
module c1d_mac
  import c1d_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mac_ctrl_t              ctrl_i,
  input  logic signed [ValW-1:0] sample_i,
  input  logic signed [ValW-1:0] weight_i,
  output logic                   busy_o,
  output logic signed [ResW-1:0] result_o
);

  logic signed [2*ValW-1:0] prod_q;
  logic                     pv_q;
  logic signed [AccW-1:0]   acc_q;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.rd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_valid) begin
      prod_q <= sample_i * weight_i;
    end
  end

  // accumulate stage, bias enters as bias * 4096
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= AccW'($signed(ctrl_i.bias)) <<< 12;
    end else if (pv_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // saturate to 32 bits
  always_comb begin
    if (acc_q > AccW'(64'sh7FFFFFFF)) begin
      result_o = {1'b0, {(ResW-1){1'b1}}};
    end else if (acc_q < -AccW'(64'sh80000000)) begin
      result_o = {1'b1, {(ResW-1){1'b0}}};
    end else begin
      result_o = acc_q[ResW-1:0];
    end
  end

  assign busy_o = pv_q;

endmodule

// ===== rtl/conv1d_same_padding_layer_top.sv =====
`timescale 1ns / 1ps
// per filter: setup, product reads from the weight and window memories, a multiply/accumulate
// drain and an output load; the next beat is taken after the last result is loaded.
// weight, bias and non-completing sample beats pass through the start state back to idle.
// reset: asynchronous, clears config to 8/3/1, counters and window valid bits;
// weight and bias stores are undefined until written
module conv1d_same_padding_layer_top
  import c1d_pkg::*;
#(
  parameter int MAX_FILTERS  = 8,
  parameter int MAX_TAPS     = 15,
  parameter int MAX_CHANNELS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [CfgAW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  // input stream
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [31:0]      s_axis_tdata_i,   // index[9:0], value[25:10], zero fill
  input  logic [1:0]       s_axis_tuser_i,   // mode[1:0]
  input  logic             s_axis_tlast_i,   // last_sample
  // output stream
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [55:0]      m_axis_tdata_o,   // position[15:0], filter_number[18:16],
                                             // result_value[50:19], zero fill
  output logic             m_axis_tlast_o    // end_of_run
);

  localparam int WDepth   = MAX_FILTERS * MAX_TAPS * MAX_CHANNELS;
  localparam int WaW      = $clog2(WDepth);
  localparam int NDepth   = MAX_TAPS * MAX_CHANNELS;
  localparam int NaW      = (NDepth > 1) ? $clog2(NDepth) : 1;
  localparam int RowW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int ChW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int BiW      = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam logic [RowW:0] TapsX = (RowW+1)'(MAX_TAPS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_ISSUE = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // configuration registers
  logic [CfgW-1:0] filt_q, taps_q, chan_q;
  logic [CfgW-1:0] nf, nk, nd, nr, kd_lo;
  logic [7:0]      kd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= CfgW'(8);
      taps_q <= CfgW'(3);
      chan_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_FILTERS:  filt_q <= cfg_wdata_i;
        CFG_TAPS:     taps_q <= cfg_wdata_i;
        CFG_CHANNELS: chan_q <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  assign nf    = clamp_cfg(filt_q, MAX_FILTERS);
  assign nk    = clamp_cfg(taps_q, MAX_TAPS);
  assign nd    = clamp_cfg(chan_q, MAX_CHANNELS);
  assign nr    = nk - CfgW'(1) - (nk >> 1);
  assign kd    = 8'(nk) * 8'(nd);
  assign kd_lo = '0;

  // input fields
  logic [IdxW-1:0]        in_idx;
  logic signed [ValW-1:0] in_val;
  logic                   accept;
  assign in_idx = s_axis_tdata_i[IdxW-1:0];
  assign in_val = s_axis_tdata_i[IdxW+ValW-1:IdxW];

  // sequencer state
  logic [2:0]      state_q, state_d;
  logic [PosW-1:0] step_q, pos_q;
  logic [ChW-1:0]  ch_q;
  logic [CfgW-1:0] warm_q, j_q, jend_q, k_q, klast_q;
  logic [RowW-1:0] head_q, row_q;
  logic [ChW-1:0]  c_q;
  logic [WaW-1:0]  addr_q, base_q;
  logic [BiW-1:0]  fil_q;
  logic            emit_q, flush_q, rd_pend_q;
  logic            out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;

  // window position of the current sample beat
  logic [RowW-1:0] head_n;
  logic            new_step, complete;
  logic [NaW-1:0]  wr_naddr, rd_naddr;
  logic [CfgW-1:0] warm_n;
  logic [CfgW-1:0] jstart;

  assign new_step = (ch_q == '0);
  assign head_n   = !new_step ? head_q :
                    (head_q == RowW'(MAX_TAPS - 1)) ? '0 : head_q + RowW'(1);
  assign wr_naddr = NaW'(32'(head_n) * MAX_CHANNELS + 32'(ch_q));
  assign rd_naddr = NaW'(32'(row_q) * MAX_CHANNELS + 32'(c_q));
  assign complete = !((CfgW'(ch_q) + CfgW'(1) < nd) && !s_axis_tlast_i);
  assign warm_n   = (warm_q < CfgW'(MAX_TAPS)) ? warm_q + CfgW'(1) : warm_q;
  assign jstart   = (warm_n >= nr + CfgW'(1)) ? '0 : nr + CfgW'(1) - warm_n;

  // first window row for the current position: head - (K-1-j), modulo taps
  logic [RowW:0]   row_sum;
  logic [RowW-1:0] row_first;
  assign row_sum   = {1'b0, head_q} + TapsX - (RowW+1)'(nk - CfgW'(1) - j_q);
  assign row_first = (row_sum >= TapsX) ? RowW'(row_sum - TapsX) : RowW'(row_sum);

  logic last_term, last_fil;
  assign last_term = (k_q == klast_q) && (CfgW'(c_q) == nd - CfgW'(1));
  assign last_fil  = (CfgW'(fil_q) == nf - CfgW'(1));

  // weight, bias and window storage
  logic signed [ValW-1:0] wmem [WDepth];
  logic signed [ValW-1:0] nmem [NDepth];
  logic signed [ValW-1:0] bias_q [MAX_FILTERS];
  logic signed [ValW-1:0] w_rd_q, n_rd_q;
  logic [NDepth-1:0]      nvalid_q, nvalid_d;
  logic                   nv_rd_q;

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser_i == MODE_WEIGHT && 32'(in_idx) < WDepth) begin
      wmem[WaW'(in_idx)] <= in_val;
    end
    w_rd_q <= wmem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser_i == MODE_SAMPLE) begin
      nmem[wr_naddr] <= in_val;
    end
    n_rd_q  <= nmem[rd_naddr];
    nv_rd_q <= nvalid_q[rd_naddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser_i == MODE_BIAS && 32'(in_idx) < MAX_FILTERS) begin
      bias_q[BiW'(in_idx)] <= in_val;
    end
  end

  // window valid bits: a row is cleared when a new step starts, all at sequence end
  always_comb begin
    nvalid_d = nvalid_q;
    if (accept && s_axis_tuser_i == MODE_SAMPLE) begin
      if (new_step) begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          nvalid_d[NaW'(32'(head_n) * MAX_CHANNELS + i)] = 1'b0;
        end
      end
      nvalid_d[wr_naddr] = 1'b1;
    end
    if (state_q == ST_OUT && out_free && last_fil && j_q == jend_q && flush_q) begin
      nvalid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvalid_q <= '0;
    end else begin
      nvalid_q <= nvalid_d;
    end
  end

  // multiply-accumulate
  mac_ctrl_t              mac_ctrl;
  logic                   mac_busy;
  logic signed [ResW-1:0] mac_res;

  assign mac_ctrl.load     = (state_q == ST_SETUP);
  assign mac_ctrl.bias     = bias_q[fil_q];
  assign mac_ctrl.rd_valid = rd_pend_q;

  c1d_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (nv_rd_q ? n_rd_q : '0),
    .weight_i (w_rd_q),
    .busy_o   (mac_busy),
    .result_o (mac_res)
  );

  // state transitions
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_START;
      ST_START: state_d = emit_q ? ST_SETUP : ST_IDLE;
      ST_SETUP: state_d = ST_ISSUE;
      ST_ISSUE: if (last_term) state_d = ST_DRAIN;
      ST_DRAIN: if (!rd_pend_q && !mac_busy) state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = (last_fil && j_q == jend_q) ? ST_IDLE : ST_SETUP;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      ch_q      <= '0;
      warm_q    <= '0;
      head_q    <= '0;
      emit_q    <= 1'b0;
      flush_q   <= 1'b0;
      rd_pend_q <= 1'b0;
      pos_q     <= '0;
      j_q       <= '0;
      jend_q    <= '0;
      k_q       <= '0;
      klast_q   <= '0;
      row_q     <= '0;
      c_q       <= '0;
      addr_q    <= '0;
      base_q    <= '0;
      fil_q     <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == ST_ISSUE);
      unique case (state_q)
        ST_IDLE: begin
          emit_q <= 1'b0;
          if (accept && s_axis_tuser_i == MODE_SAMPLE) begin
            head_q <= head_n;
            if (!complete) begin
              ch_q <= ch_q + ChW'(1);
            end else begin
              ch_q   <= '0;
              step_q <= step_q + PosW'(1);
              warm_q <= warm_n;
              if (s_axis_tlast_i) begin
                emit_q  <= 1'b1;
                flush_q <= 1'b1;
                j_q     <= jstart;
                jend_q  <= nr;
                pos_q   <= step_q - PosW'(nr) + PosW'(jstart);
              end else begin
                emit_q <= (warm_n >= nr + CfgW'(1));
                j_q    <= '0;
                jend_q <= '0;
                pos_q  <= step_q - PosW'(nr);
              end
            end
          end
          fil_q  <= '0;
          base_q <= '0;
        end
        ST_SETUP: begin
          addr_q  <= base_q;
          k_q     <= kd_lo;
          c_q     <= '0;
          row_q   <= row_first;
          klast_q <= nk - CfgW'(1) - j_q;
        end
        ST_ISSUE: begin
          addr_q <= addr_q + WaW'(1);
          if (CfgW'(c_q) == nd - CfgW'(1)) begin
            c_q   <= '0;
            k_q   <= k_q + CfgW'(1);
            row_q <= (row_q == RowW'(MAX_TAPS - 1)) ? '0 : row_q + RowW'(1);
          end else begin
            c_q <= c_q + ChW'(1);
          end
        end
        ST_OUT: begin
          if (out_free) begin
            if (!last_fil) begin
              fil_q  <= fil_q + BiW'(1);
              base_q <= base_q + WaW'(kd);
            end else if (j_q != jend_q) begin
              fil_q  <= '0;
              base_q <= '0;
              j_q    <= j_q + CfgW'(1);
              pos_q  <= pos_q + PosW'(1);
            end else if (flush_q) begin
              flush_q <= 1'b0;
              step_q  <= '0;
              ch_q    <= '0;
              warm_q  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  logic        mvalid_q;
  logic [55:0] mdata_q;
  logic        mlast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      mvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      mvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      mdata_q <= {5'b0, mac_res, FilW'(fil_q), pos_q};
      mlast_q <= last_fil && (j_q == jend_q);
    end
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tlast_o  = mlast_q;

endmodule

// ===== rtl/c1d_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the convolution layer, bound to the top level
// depends on conv1d_same_padding_layer_top
module c1d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // no result is offered while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // every accepted beat leaves the sequencer busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken on consecutive cycles");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

endmodule

bind conv1d_same_padding_layer_top c1d_checker u_c1d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== test/conv1d_checker.sv =====
`timescale 1ns / 1ps
// checker for the 1-d convolution layer: watches both streams and config writes,
// predicts every result beat and compares; depends on c1d_pkg
module conv1d_checker
  import c1d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgAW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [31:0]      s_tdata_i,
  input  logic [1:0]       s_tuser_i,
  input  logic             s_tlast_i,
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [55:0]      m_tdata_i,
  input  logic             m_tlast_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o
);

  localparam int NF = 8, NK = 15, NC = 8, WDEPTH = NF * NK * NC;

  typedef struct packed {
    logic [15:0] pos;
    logic [2:0]  fil;
    logic [31:0] val;
    logic        eor;
  } conv_out_t;

  conv_out_t   expected_q[$];
  logic [3:0]  nfil, ntap, nch;
  logic signed [15:0] win [NK][NC];
  logic signed [15:0] wts [WDEPTH];
  logic signed [15:0] bias [NF];
  logic [15:0] steps;
  int          chan, warmup;

  function automatic int clip(int v, int hi);
    return v < 1 ? 1 : (v > hi ? hi : v);
  endfunction

  // sums of one output position, all filters
  task automatic push_position(int j, int r, logic [15:0] t, int f_n, int k_n, int d_n);
    conv_out_t o;
    longint acc;
    int dd;
    for (int f = 0; f < f_n; f++) begin
      acc = longint'(bias[f]) * 4096;
      for (int k = 0; k < k_n; k++) begin
        dd = k_n - 1 - j - k;
        if (dd < 0) continue;
        for (int c = 0; c < d_n; c++)
          acc += longint'(win[dd][c]) * longint'(wts[(f * k_n + k) * d_n + c]);
      end
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      o.pos = t - 16'(r) + 16'(j);
      o.fil = 3'(f);
      o.val = acc[31:0];
      o.eor = 1'b0;
      expected_q.push_back(o);
    end
  endtask

  task automatic clear_window();
    foreach (win[i, c]) win[i][c] = '0;
    steps = '0;
    chan = 0;
    warmup = 0;
  endtask

  // one accepted input beat
  task automatic predict_beat(logic [1:0] md, int idx, logic signed [15:0] v, logic lst);
    int f_n, k_n, d_n, r, j, before_n;
    logic [15:0] t;
    f_n = clip(nfil, NF);
    k_n = clip(ntap, NK);
    d_n = clip(nch, NC);
    r = k_n - 1 - k_n / 2;
    before_n = expected_q.size();
    if (md == MODE_WEIGHT) begin
      if (idx < WDEPTH) wts[idx] = v;
    end else if (md == MODE_BIAS) begin
      if (idx < NF) bias[idx] = v;
    end else if (md == MODE_SAMPLE) begin
      if (chan == 0) begin
        for (int i = NK - 1; i > 0; i--) win[i] = win[i - 1];
        for (int c = 0; c < NC; c++) win[0][c] = '0;
      end
      win[0][chan] = v;
      if (chan + 1 < d_n && !lst) begin
        chan++;
      end else begin
        chan = 0;
        t = steps;
        steps++;
        if (warmup < NK) warmup++;
        if (!lst) begin
          if (warmup >= r + 1) push_position(0, r, t, f_n, k_n, d_n);
        end else begin
          j = (warmup >= r + 1) ? 0 : r + 1 - warmup;
          for (; j <= r; j++) push_position(j, r, t, f_n, k_n, d_n);
          clear_window();
        end
        if (expected_q.size() > before_n) expected_q[$].eor = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    conv_out_t got, exp_o;
    int n_err;
    n_err = 0;
    if (!rst_ni) begin
      nfil = 4'd8; ntap = 4'd3; nch = 4'd1;
      foreach (wts[i]) wts[i] = '0;
      foreach (bias[i]) bias[i] = '0;
      clear_window();
      expected_q.delete();
      errors_o <= 0;
      results_o <= 0;
    end else begin
      // config writes
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_FILTERS:  nfil = cfg_wdata_i;
          CFG_TAPS:     ntap = cfg_wdata_i;
          CFG_CHANNELS: nch = cfg_wdata_i;
          default: ;
        endcase
      end
      // result beats
      if (m_tvalid_i && m_tready_i) begin
        got.pos = m_tdata_i[15:0];
        got.fil = m_tdata_i[18:16];
        got.val = m_tdata_i[50:19];
        got.eor = m_tlast_i;
        results_o <= results_o + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result beat pos=%0d filter=%0d", got.pos, got.fil);
          n_err++;
        end else begin
          exp_o = expected_q.pop_front();
          if (got.pos !== exp_o.pos) begin
            $error("position: expected %0d, actual %0d", exp_o.pos, got.pos);
            n_err++;
          end
          if (got.fil !== exp_o.fil) begin
            $error("filter_number: expected %0d, actual %0d", exp_o.fil, got.fil);
            n_err++;
          end
          if (got.val !== exp_o.val) begin
            $error("result_value: expected %0d, actual %0d",
                   $signed(exp_o.val), $signed(got.val));
            n_err++;
          end
          if (got.eor !== exp_o.eor) begin
            $error("end_of_run: expected %0d, actual %0d", exp_o.eor, got.eor);
            n_err++;
          end
        end
      end
      if (n_err != 0) errors_o <= errors_o + n_err;
      // input beats
      if (s_tvalid_i && s_tready_i)
        predict_beat(s_tuser_i, int'(s_tdata_i[9:0]), s_tdata_i[25:10], s_tlast_i);
    end
  end

  assign pending_o = expected_q.size();

endmodule

// ===== test/tb_conv1d_same_padding_layer_top.sv =====
`timescale 1ns / 1ps
// testbench top for the 1-d convolution layer: clock, reset, stimulus and verdict
// depends on c1d_pkg, conv1d_same_padding_layer_top and conv1d_checker
module tb_conv1d_same_padding_layer_top;
  import c1d_pkg::*;

  localparam int CYCLE_LIMIT = 900000;

  logic             clk_i, rst_ni;
  logic             cfg_we_i;
  logic [CfgAW-1:0] cfg_addr_i;
  logic [CfgW-1:0]  cfg_wdata_i;
  logic             s_tvalid, s_tready, s_tlast;
  logic [31:0]      s_tdata;
  logic [1:0]       s_tuser;
  logic             m_tvalid, m_tready, m_tlast;
  logic [55:0]      m_tdata;
  int               errors, pending, results, cycles, beats_sent;
  bit               calm, hold_long;
  int               cur_k, cur_d, cur_f;

  conv1d_same_padding_layer_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser), .s_axis_tlast_i(s_tlast),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tlast_o(m_tlast)
  );

  conv1d_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .s_tuser_i(s_tuser), .s_tlast_i(s_tlast),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .m_tlast_i(m_tlast), .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        m_tready <= 1'b0;
        repeat (600) @(negedge clk_i);
        hold_long = 0;
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        m_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // one input beat, sometimes with a random gap before it; valid stays up until the caller idles
  task automatic send(logic [1:0] md, logic [9:0] idx, logic [15:0] v, logic lst);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= md;
    s_tdata <= {6'b0, v, idx};
    s_tlast <= lst;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    beats_sent++;
  endtask

  task automatic write_reg(logic [CfgAW-1:0] a, logic [CfgW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= a;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2100) @(negedge clk_i);
  endtask

  // set geometry and load every weight and bias it reads
  task automatic setup(int f, int k, int d, bit rand_vals);
    cur_f = f; cur_k = k; cur_d = d;
    write_reg(CFG_FILTERS, 4'(f));
    write_reg(CFG_TAPS, 4'(k));
    write_reg(CFG_CHANNELS, 4'(d));
    for (int i = 0; i < f * k * d; i++)
      send(MODE_WEIGHT, 10'(i), rand_vals ? 16'($urandom) : 16'h1000, 1'b0);
    for (int i = 0; i < f; i++)
      send(MODE_BIAS, 10'(i), rand_vals ? 16'($urandom) : 16'h0000, 1'b0);
  endtask

  task automatic sequence_run(int steps, bit cut_mid);
    int total;
    total = steps * cur_d - (cut_mid && cur_d > 1 ? 1 : 0);
    for (int i = 0; i < total; i++)
      send(MODE_SAMPLE, 10'($urandom), 16'($urandom), i == total - 1);
  endtask

  initial begin
    cfg_we_i = 0; cfg_addr_i = '0; cfg_wdata_i = '0;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0; s_tlast = 0;
    calm = 0; hold_long = 0; cycles = 0; beats_sent = 0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extreme values, ignored beats, single-step sequence
    setup(2, 3, 1, 0);
    send(MODE_WEIGHT, 10'd0, 16'h7fff, 1'b0);
    send(MODE_WEIGHT, 10'd1, 16'h8000, 1'b0);
    send(MODE_BIAS, 10'd1, 16'h7fff, 1'b0);
    send(MODE_WEIGHT, 10'd1023, 16'hffff, 1'b0);   // out-of-range weight
    send(MODE_BIAS, 10'd8, 16'h1234, 1'b0);        // out-of-range bias
    send(2'd3, 10'h3ff, 16'hffff, 1'b1);           // unused mode
    send(MODE_SAMPLE, 10'h3ff, 16'h8000, 1'b0);
    send(MODE_SAMPLE, 10'h000, 16'h7fff, 1'b0);
    send(MODE_SAMPLE, 10'h155, 16'h8000, 1'b1);
    send(MODE_SAMPLE, 10'h2aa, 16'h7fff, 1'b1);    // one-step sequence
    drain();
    // several channels with unity weights, sequence ends mid-step
    setup(2, 3, 4, 0);
    sequence_run(2, 1);
    drain();
    // register zero and too-large values
    write_reg(CFG_FILTERS, 4'd0);
    write_reg(CFG_TAPS, 4'd0);
    write_reg(CFG_CHANNELS, 4'd15);
    cur_d = 8;
    sequence_run(1, 0);
    drain();

    // pressure: hold the receiver while a sequence streams in
    setup(2, 2, 1, 1);
    hold_long = 1;
    sequence_run(6, 0);
    drain();

    // random sequences over assorted small geometries
    for (int s = 0; s < 3; s++) begin
      if (s == 2) calm = 1;
      setup($urandom_range(1, 3), $urandom_range(1, 4), $urandom_range(1, 2), 1);
      sequence_run($urandom_range(1, 6), $urandom_range(0, 1));
      drain();
    end

    $display("sent %0d input beats across several geometries; checked %0d results",
             beats_sent, results);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
